// ===== rtl/core/stcm_pkg.sv =====
// ----------------------------------------------------------------------------
// stcm_pkg
// Shared types, register codes and color tables for the scalar colormap.
// ----------------------------------------------------------------------------
package stcm_pkg;

    localparam int VALUE_FRAC_BITS_DEF = 8;

    localparam int VAL_W  = 24;
    localparam int CH_W   = 8;
    localparam int MAP_W  = 3;
    localparam int QUO_W  = 16;
    localparam int T_W    = 17;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_RANGE_MIN = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_RANGE_MAX = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_MAP_TYPE  = 4'd8;

    // map codes; codes above white also give white
    localparam logic [MAP_W-1:0] MAP_RAINBOW = 3'd0;
    localparam logic [MAP_W-1:0] MAP_GRAY    = 3'd1;
    localparam logic [MAP_W-1:0] MAP_HEAT    = 3'd2;
    localparam logic [MAP_W-1:0] MAP_VIRIDIS = 3'd3;
    localparam logic [MAP_W-1:0] MAP_WHITE   = 3'd4;

    localparam logic [VAL_W-1:0] RANGE_MIN_RST = '0;
    localparam logic [VAL_W-1:0] RANGE_MAX_RST = 24'd25600;

    // heat map breakpoints, t scaled by 100 (0.33 and 0.66 of 2^16)
    localparam logic [22:0] HEAT_P1 = 23'd2162688;
    localparam logic [22:0] HEAT_P2 = 23'd4325376;
    localparam logic [22:0] HEAT_P3 = 23'd2228224;

    typedef enum logic [1:0] {
        HEAT_LOW  = 2'd0,
        HEAT_MID  = 2'd1,
        HEAT_HIGH = 2'd2
    } heat_region_t;

    // one item inside the divider pipeline
    typedef struct packed {
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        logic             sat_zero;
        logic             sat_one;
        logic [MAP_W-1:0] map;
    } div_item_t;

    // floor(255 * x / 1e6 + 1/2), x in millionths; evaluated on constants only
    function automatic logic [CH_W-1:0] chan_m(input longint x);
        chan_m = CH_W'((510 * x + 1000000) / 2000000);
    endfunction

    function automatic logic [3*CH_W-1:0] vir_rgb(input logic [4:0] idx);
        case (idx)
            5'd0:  vir_rgb = {chan_m(267004), chan_m(4874),   chan_m(329415)};
            5'd1:  vir_rgb = {chan_m(268510), chan_m(9605),   chan_m(335427)};
            5'd2:  vir_rgb = {chan_m(269944), chan_m(14625),  chan_m(341379)};
            5'd3:  vir_rgb = {chan_m(271305), chan_m(19942),  chan_m(347269)};
            5'd4:  vir_rgb = {chan_m(272594), chan_m(25563),  chan_m(353093)};
            5'd5:  vir_rgb = {chan_m(273809), chan_m(31497),  chan_m(358853)};
            5'd6:  vir_rgb = {chan_m(274952), chan_m(37752),  chan_m(364543)};
            5'd7:  vir_rgb = {chan_m(276022), chan_m(44167),  chan_m(370164)};
            5'd8:  vir_rgb = {chan_m(277018), chan_m(50344),  chan_m(375715)};
            5'd9:  vir_rgb = {chan_m(277941), chan_m(56324),  chan_m(381191)};
            5'd10: vir_rgb = {chan_m(278791), chan_m(62145),  chan_m(386592)};
            5'd11: vir_rgb = {chan_m(279566), chan_m(67836),  chan_m(391917)};
            5'd12: vir_rgb = {chan_m(280267), chan_m(73417),  chan_m(397163)};
            5'd13: vir_rgb = {chan_m(280894), chan_m(78907),  chan_m(402329)};
            5'd14: vir_rgb = {chan_m(281446), chan_m(84320),  chan_m(407414)};
            5'd15: vir_rgb = {chan_m(281924), chan_m(89666),  chan_m(412415)};
            5'd16: vir_rgb = {chan_m(282327), chan_m(94955),  chan_m(417331)};
            5'd17: vir_rgb = {chan_m(282656), chan_m(100196), chan_m(422160)};
            5'd18: vir_rgb = {chan_m(282910), chan_m(105393), chan_m(426902)};
            5'd19: vir_rgb = {chan_m(283091), chan_m(110553), chan_m(431554)};
            5'd20: vir_rgb = {chan_m(283197), chan_m(115680), chan_m(436115)};
            5'd21: vir_rgb = {chan_m(283229), chan_m(120777), chan_m(440584)};
            5'd22: vir_rgb = {chan_m(283187), chan_m(125848), chan_m(444960)};
            5'd23: vir_rgb = {chan_m(283072), chan_m(130895), chan_m(449241)};
            default: vir_rgb = {chan_m(282884), chan_m(135920), chan_m(453427)};
        endcase
    endfunction

    // y / 33, exact for y < 32768
    function automatic logic [CH_W-1:0] div33(input logic [14:0] y);
        logic [35:0] p;
        p = 36'(y) * 36'd31776;
        div33 = CH_W'(p >> 20);
    endfunction

    // y / 17, exact for y < 32768
    function automatic logic [CH_W-1:0] div17(input logic [14:0] y);
        logic [35:0] p;
        p = 36'(y) * 36'd61681;
        div17 = CH_W'(p >> 20);
    endfunction

endpackage

// ===== rtl/core/scalar_to_rgb_colormap.sv =====
// Pipeline: 1 range stage, 16 divider stages and 3 color stages, all registered.
// Throughput: one transaction per cycle while the output is not stalled; the 16-stage
// restoring divider retires one quotient bit per stage.
// A stall on the output freezes the whole pipeline.
// Reset: pipeline empty, range_min 0, range_max 100.0, map rainbow.
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap
// Normalizes a Q16.8 sample against a configured range and maps it to RGB.
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap
    import stcm_pkg::*;
#(
    parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [VAL_W-1:0] sample_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CH_W-1:0]     red,
    output logic [CH_W-1:0]     green,
    output logic [CH_W-1:0]     blue
);

    // largest range (in LSBs) still treated as degenerate
    localparam int RNG_MIN = (1 << VALUE_FRAC_BITS) / 10000;
    localparam int DW      = VAL_W + 2;
    localparam int NSTG    = QUO_W;

    logic signed [VAL_W-1:0] range_min_reg;
    logic signed [VAL_W-1:0] range_max_reg;
    logic [MAP_W-1:0]        map_type_reg;

    logic cfg_wr;
    logic adv;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RANGE_MIN_RST;
            range_max_reg <= RANGE_MAX_RST;
            map_type_reg  <= MAP_RAINBOW;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                ADDR_RANGE_MIN: range_min_reg <= pwdata[VAL_W-1:0];
                ADDR_RANGE_MAX: range_max_reg <= pwdata[VAL_W-1:0];
                ADDR_MAP_TYPE:  map_type_reg  <= pwdata[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_RANGE_MIN: prdata = DATA_W'(range_min_reg);
            ADDR_RANGE_MAX: prdata = DATA_W'(range_max_reg);
            ADDR_MAP_TYPE:  prdata = DATA_W'(map_type_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- range stage ----------------
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] rng;
    logic                 rng_ok;
    div_item_t            entry;

    always_comb
    begin
        diff   = DW'(sample_value) - DW'(range_min_reg);
        rng    = DW'(range_max_reg) - DW'(range_min_reg);
        rng_ok = rng > $signed(DW'(RNG_MIN));
        entry.rem      = diff[VAL_W-1:0];
        entry.dvs      = rng[VAL_W-1:0];
        entry.quo      = '0;
        entry.sat_zero = !rng_ok || (diff <= $signed(DW'(0)));
        entry.sat_one  = rng_ok && (diff >= rng);
        entry.map      = map_type_reg;
    end

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ---------------- divider pipeline ----------------
    div_item_t div_reg   [0:NSTG];
    logic      div_v_reg [0:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_v_reg[0] <= 1'b0;
        else if (adv)
            div_v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            div_reg[0] <= entry;
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        div_item_t          stg_next;
        logic [VAL_W:0]     shl;
        logic               ge;

        always_comb
        begin
            stg_next = div_reg[k];
            shl      = {div_reg[k].rem, 1'b0};
            ge       = shl >= {1'b0, div_reg[k].dvs};
            stg_next.rem = ge ? VAL_W'(shl - {1'b0, div_reg[k].dvs}) : shl[VAL_W-1:0];
            stg_next.quo = {div_reg[k].quo[QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v_reg[k+1] <= 1'b0;
            else if (adv)
                div_v_reg[k+1] <= div_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                div_reg[k+1] <= stg_next;
        end
    end

    // ---------------- color stage 1 ----------------
    logic [T_W-1:0]  t_val;
    logic [19:0]     u_val;
    logic [2:0]      seg;
    logic [T_W-1:0]  nn;
    logic [T_W-1:0]  nn_inv;
    logic [CH_W-1:0] c_n;
    logic [CH_W-1:0] c_inv;
    logic [CH_W-1:0] c_b0;
    logic [CH_W-1:0] c_gray;
    logic [20:0]     t24;
    logic [3*CH_W-1:0] rgb1_next;
    logic [22:0]     v_next;

    always_comb
    begin
        if (div_reg[NSTG].sat_one)
            t_val = T_W'(1 << QUO_W);
        else if (div_reg[NSTG].sat_zero)
            t_val = '0;
        else
            t_val = {1'b0, div_reg[NSTG].quo};

        u_val = 20'(t_val) * 20'd5;
        seg   = (u_val[19:16] > 4'd4) ? 3'd4 : u_val[18:16];
        nn    = T_W'(u_val - {1'b0, seg, 16'd0});
        nn_inv = T_W'(1 << QUO_W) - nn;
        c_n    = CH_W'((27'(nn) * 27'd510 + 27'd65536) >> 17);
        c_inv  = CH_W'((27'(nn_inv) * 27'd510 + 27'd65536) >> 17);
        c_b0   = CH_W'((28'(nn + T_W'(1 << QUO_W)) * 28'd510 + 28'd131072) >> 18);
        c_gray = CH_W'((27'(t_val) * 27'd510 + 27'd65536) >> 17);
        t24    = 21'(t_val) * 21'd24;
        v_next = 23'(t_val) * 23'd100;

        case (div_reg[NSTG].map)
            MAP_RAINBOW:
            begin
                case (seg)
                    3'd0:    rgb1_next = {8'd0, 8'd0, c_b0};
                    3'd1:    rgb1_next = {8'd0, c_n, 8'd255};
                    3'd2:    rgb1_next = {8'd0, 8'd255, c_inv};
                    3'd3:    rgb1_next = {c_n, 8'd255, 8'd0};
                    default: rgb1_next = {8'd255, c_inv, 8'd0};
                endcase
            end
            MAP_GRAY:    rgb1_next = {c_gray, c_gray, c_gray};
            MAP_VIRIDIS: rgb1_next = vir_rgb(t24[20:16]);
            default:     rgb1_next = '1;
        endcase
    end

    logic              s1_v_reg;
    logic [3*CH_W-1:0] s1_rgb_reg;
    logic [22:0]       s1_v_val_reg;
    logic              s1_heat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= div_v_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rgb_reg   <= rgb1_next;
            s1_v_val_reg <= v_next;
            s1_heat_reg  <= div_reg[NSTG].map == MAP_HEAT;
        end
    end

    // ---------------- color stage 2: heat numerators ----------------
    heat_region_t region_next;
    logic [32:0]  acc_r;
    logic [32:0]  acc_b;
    logic [32:0]  acc_g;
    logic [14:0]  yr_next;
    logic [14:0]  yb_next;
    logic [14:0]  yg_next;

    always_comb
    begin
        acc_r = '0;
        acc_b = '0;
        acc_g = '0;
        if (s1_v_val_reg < HEAT_P1)
        begin
            region_next = HEAT_LOW;
            acc_b = 33'(s1_v_val_reg) * 33'd510 + 33'(HEAT_P1);
        end
        else if (s1_v_val_reg < HEAT_P2)
        begin
            region_next = HEAT_MID;
            acc_r = 33'(s1_v_val_reg - HEAT_P1) * 33'd510 + 33'(HEAT_P1);
            acc_b = 33'(HEAT_P2 - s1_v_val_reg) * 33'd510 + 33'(HEAT_P1);
        end
        else
        begin
            region_next = HEAT_HIGH;
            acc_g = 33'(s1_v_val_reg - HEAT_P2) * 33'd510 + 33'(HEAT_P3);
        end
        yr_next = 15'(acc_r >> 17);
        yb_next = 15'(acc_b >> 17);
        yg_next = 15'(acc_g >> 18);
    end

    logic              s2_v_reg;
    logic [3*CH_W-1:0] s2_rgb_reg;
    logic              s2_heat_reg;
    heat_region_t      s2_region_reg;
    logic [14:0]       s2_yr_reg;
    logic [14:0]       s2_yb_reg;
    logic [14:0]       s2_yg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rgb_reg    <= s1_rgb_reg;
            s2_heat_reg   <= s1_heat_reg;
            s2_region_reg <= region_next;
            s2_yr_reg     <= yr_next;
            s2_yb_reg     <= yb_next;
            s2_yg_reg     <= yg_next;
        end
    end

    // ---------------- color stage 3: output register ----------------
    logic [3*CH_W-1:0] rgb3_next;

    always_comb
    begin
        if (s2_heat_reg)
        begin
            case (s2_region_reg)
                HEAT_LOW:  rgb3_next = {8'd0, 8'd0, div33(s2_yb_reg)};
                HEAT_MID:  rgb3_next = {div33(s2_yr_reg), 8'd0, div33(s2_yb_reg)};
                default:   rgb3_next = {8'd255, div17(s2_yg_reg), 8'd0};
            endcase
        end
        else
        begin
            rgb3_next = s2_rgb_reg;
        end
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            {red, green, blue} <= rgb3_next;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== verif/colormap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colormap_checker
// Watches the sample and color channels, predicts each RGB result from the
// sample and the register settings seen on the APB port, and compares them.
// ----------------------------------------------------------------------------
module colormap_checker
    import stcm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [CH_W-1:0]         red,
    input  logic [CH_W-1:0]         green,
    input  logic [CH_W-1:0]         blue,
    output int                      fail_count,
    output int                      pending_colors
);

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    longint lo_q, hi_q;
    logic [MAP_W-1:0] map_q;
    rgb_t color_q[$];

    // viridis table in millionths
    longint vir_r[25] = '{267004, 268510, 269944, 271305, 272594, 273809, 274952,
        276022, 277018, 277941, 278791, 279566, 280267, 280894, 281446, 281924,
        282327, 282656, 282910, 283091, 283197, 283229, 283187, 283072, 282884};
    longint vir_g[25] = '{4874, 9605, 14625, 19942, 25563, 31497, 37752, 44167,
        50344, 56324, 62145, 67836, 73417, 78907, 84320, 89666, 94955, 100196,
        105393, 110553, 115680, 120777, 125848, 130895, 135920};
    longint vir_b[25] = '{329415, 335427, 341379, 347269, 353093, 358853, 364543,
        370164, 375715, 381191, 386592, 391917, 397163, 402329, 407414, 412415,
        417331, 422160, 426902, 431554, 436115, 440584, 444960, 449241, 453427};

    function automatic logic [CH_W-1:0] scale255(longint num, longint den);
        longint c;
        c = (510 * num + den) / (2 * den);
        return (c > 255) ? 8'd255 : CH_W'(c);
    endfunction

    function automatic rgb_t color_of(longint v);
        longint span, diff, t, u, seg, n, h, p1, p2, idx;
        rgb_t c;
        span = hi_q - lo_q;
        diff = v - lo_q;
        t = 0;
        c = '{8'd255, 8'd255, 8'd255};
        if (span > 0 && span * 10000 > 256)
        begin
            if (diff <= 0)
                t = 0;
            else if (diff >= span)
                t = 65536;
            else
                t = (diff <<< 16) / span;
        end
        case (map_q)
            MAP_RAINBOW:
            begin
                u = 5 * t;
                seg = u >>> 16;
                if (seg > 4)
                    seg = 4;
                n = u - seg * 65536;
                case (seg)
                    0: c = '{8'd0, 8'd0, scale255(65536 + n, 131072)};
                    1: c = '{8'd0, scale255(n, 65536), 8'd255};
                    2: c = '{8'd0, 8'd255, scale255(65536 - n, 65536)};
                    3: c = '{scale255(n, 65536), 8'd255, 8'd0};
                    default: c = '{8'd255, scale255(65536 - n, 65536), 8'd0};
                endcase
            end
            MAP_GRAY:
            begin
                c.r = scale255(t, 65536);
                c.g = c.r;
                c.b = c.r;
            end
            MAP_HEAT:
            begin
                h = 100 * t;
                p1 = 33 * 65536;
                p2 = 66 * 65536;
                if (h < p1)
                    c = '{8'd0, 8'd0, scale255(h, p1)};
                else if (h < p2)
                    c = '{scale255(h - p1, p1), 8'd0, scale255(p2 - h, p1)};
                else
                    c = '{8'd255, scale255(h - p2, 34 * 65536), 8'd0};
            end
            MAP_VIRIDIS:
            begin
                idx = (t * 24) >>> 16;
                if (idx > 24)
                    idx = 24;
                c = '{scale255(vir_r[idx], 1000000), scale255(vir_g[idx], 1000000),
                      scale255(vir_b[idx], 1000000)};
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending_colors = color_q.size();

    initial
        fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        if (!rst_n)
        begin
            lo_q  = 0;
            hi_q  = 25600;
            map_q = MAP_RAINBOW;
            color_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                color_q.push_back(color_of(longint'(sample_value)));
            if (out_valid && !out_stall)
            begin
                if (color_q.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = color_q.pop_front();
                    if (red !== want.r)
                        report_mismatch("red", red, want.r);
                    if (green !== want.g)
                        report_mismatch("green", green, want.g);
                    if (blue !== want.b)
                        report_mismatch("blue", blue, want.b);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_RANGE_MIN: lo_q = longint'(signed'(pwdata[VAL_W-1:0]));
                    ADDR_RANGE_MAX: hi_q = longint'(signed'(pwdata[VAL_W-1:0]));
                    ADDR_MAP_TYPE:  map_q = pwdata[MAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives samples through the colormap over many range and map settings with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb
    import stcm_pkg::*;
();

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [VAL_W-1:0] sample_value;
    logic [CH_W-1:0] red, green, blue;
    int fail_count, pending_colors;
    bit calm;

    scalar_to_rgb_colormap u_dut (.*);

    colormap_checker u_chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_valid(in_valid),
        .in_stall(in_stall), .sample_value(sample_value), .out_valid(out_valid),
        .out_stall(out_stall), .red(red), .green(green), .blue(blue),
        .fail_count(fail_count), .pending_colors(pending_colors)
    );

    initial
    begin
        clk = 0;
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // output stall in random bursts
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 18);
                out_stall <= 1;
                repeat (n)
                    @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic reg_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 0;
        @(posedge clk);
        while (pending_colors != 0)
            @(posedge clk);
        repeat (25)
            @(posedge clk);
    endtask

    task automatic configure(int lo, int hi, int m);
        settle();
        reg_write(ADDR_RANGE_MIN, DATA_W'(lo));
        reg_write(ADDR_RANGE_MAX, DATA_W'(hi));
        reg_write(ADDR_MAP_TYPE, DATA_W'(m));
    endtask

    // in_valid stays high between back-to-back transactions
    task automatic send_sample(logic [VAL_W-1:0] v, bit gaps);
        int n;
        if (gaps && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 18);
            in_valid <= 0;
            repeat (n)
                @(posedge clk);
        end
        in_valid <= 1;
        sample_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_sample(int lo, int hi);
        longint a, b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 5))
            0: return VAL_W'($urandom);
            1: return VAL_W'(a + $urandom_range(0, 3) - 1);
            2: return VAL_W'(b + $urandom_range(0, 3) - 1);
            default: return VAL_W'(a + longint'($urandom) % (b - a + 1));
        endcase
    endfunction

    initial
    begin
        int lo, hi, m;
        logic [VAL_W-1:0] dir[$];
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; sample_value = '0; calm = 0;
        rst_n = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset range, then map codes 1 to 7, each over half the edges and breakpoints
        dir = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'd5120, 24'd10240,
                24'd12800, 24'd15360, 24'd20480, 24'd25599, 24'd25600, 24'd8448,
                24'd16896, 24'h555555, 24'hAAAAAA};
        foreach (dir[i])
            send_sample(dir[i], 0);
        for (int k = 1; k < 8; k++)
        begin
            configure(0, 25600, k);
            foreach (dir[i])
                if (i % 2 == k % 2)
                    send_sample(dir[i], 0);
        end
        // edge ranges: equal and inverted (degenerate), tiny, and the full extremes
        configure(100, 100, MAP_GRAY);
        send_sample(24'd100, 0);
        configure(8388607, -8388608, MAP_HEAT);
        send_sample(24'd0, 0);
        configure(0, 1, MAP_RAINBOW);
        send_sample(24'd1, 0);
        configure(-8388608, 8388607, MAP_GRAY);
        send_sample(24'h7FFFFF, 0);
        send_sample(24'h800000, 0);

        for (int ph = 0; ph < 24; ph++)
        begin
            lo = int'(signed'(VAL_W'($urandom)));
            hi = int'(signed'(VAL_W'($urandom)));
            case (ph % 4)
                0: hi = lo + $urandom_range(0, 4000);
                1: if (hi < lo) {lo, hi} = {hi, lo};
                default: ;
            endcase
            if (hi > 8388607)
                hi = 8388607;
            m = (ph < 20) ? ph % 5 : $urandom_range(0, 7);
            configure(lo, hi, m);
            if (ph == 22)
                calm = 1;
            for (int i = 0; i < 50; i++)
                send_sample(pick_sample(lo, hi), !calm);
        end

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
